>>> rtl/assert_macros.svh
// assertion macros used by order_command_line_parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, idle during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ocl_pkg.sv
// ----------------------------------------------------------------------------
// ocl_pkg
// constants and types for the order command line parser
// ----------------------------------------------------------------------------
package ocl_pkg;

    localparam int MAX_TOKENS       = 6;
    localparam int PRICE_BITS       = 64;
    localparam int QTY_BITS         = 32;
    localparam int HANDLE_BITS      = 64;
    localparam int PARTICIPANT_BITS = 32;

    localparam int KW_COUNT  = 9;
    localparam int PART_LEN  = 12;

    // keyword indexes
    localparam int KW_LIMIT  = 0;
    localparam int KW_MARKET = 1;
    localparam int KW_CANCEL = 2;
    localparam int KW_BID    = 3;
    localparam int KW_ASK    = 4;
    localparam int KW_GTC    = 5;
    localparam int KW_IOC    = 6;
    localparam int KW_FOK    = 7;
    localparam int KW_PART   = 8;

    typedef enum logic [3:0] {
        ERR_NONE  = 4'd0,
        ERR_EMPTY = 4'd1,
        ERR_CMD   = 4'd2,
        ERR_SIDE  = 4'd3,
        ERR_PRICE = 4'd4,
        ERR_QTY   = 4'd5,
        ERR_HANDLE= 4'd6,
        ERR_TIF   = 4'd7,
        ERR_PART  = 4'd8,
        ERR_COUNT = 4'd9
    } err_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_LIMIT  = 2'd1,
        CMD_MARKET = 2'd2,
        CMD_CANCEL = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        NK_NONE   = 3'd0,
        NK_PRICE  = 3'd1,
        NK_QTY    = 3'd2,
        NK_HANDLE = 3'd3,
        NK_PART   = 3'd4
    } nkind_t;

    // time-in-force codes
    typedef enum logic [1:0] {
        TIF_GTC = 2'd0,
        TIF_IOC = 2'd1,
        TIF_FOK = 2'd2
    } tif_t;

    // keyword text lookup, 8'h00 past the end
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        logic [12*8-1:0] s;
        begin
            case (k)
                KW_LIMIT:  s = {"LIMIT",  56'h0};
                KW_MARKET: s = {"MARKET", 48'h0};
                KW_CANCEL: s = {"CANCEL", 48'h0};
                KW_BID:    s = {"BID",    72'h0};
                KW_ASK:    s = {"ASK",    72'h0};
                KW_GTC:    s = {"GTC",    72'h0};
                KW_IOC:    s = {"IOC",    72'h0};
                KW_FOK:    s = {"FOK",    72'h0};
                default:   s = "PARTICIPANT=";
            endcase
            if (pos < 4'd12)
                kw_char = s[(11 - int'(pos))*8 +: 8];
            else
                kw_char = 8'h00;
        end
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        begin
            case (k) inside
                KW_LIMIT:               kw_len = 4'd5;
                KW_MARKET, KW_CANCEL:   kw_len = 4'd6;
                KW_PART:                kw_len = 4'd12;
                default:                kw_len = 4'd3;
            endcase
        end
    endfunction

    function automatic logic [63:0] umax(input int bits);
        begin
            if (bits >= 64) umax = '1;
            else umax = (64'd1 << bits) - 64'd1;
        end
    endfunction

endpackage

>>> rtl/order_command_line_parser.sv
// ----------------------------------------------------------------------------
// order_command_line_parser
// parses one order command line, one character per transaction
// ----------------------------------------------------------------------------
// Input channel: char_code/has_char/end_of_line/line_seq under in_valid and
// in_ready. Every character is folded into the line state in the cycle it is
// accepted: keyword match flags, token count and one multiply-by-ten
// accumulate, so one character is taken every cycle unless a line end stalls.
// A transaction with end_of_line set closes the line; in the cycle after it the
// result (error_code plus order fields, or an error) is shown on the output
// channel under out_valid and out_ready. Throughput is one transaction per
// cycle unless a line end waits on an untaken result.
// The result register is a single stage: while it holds an untaken result
// in_ready follows out_ready, so a new line end can overwrite it only in the
// cycle the old one leaves. Characters that end no line are taken whatever
// the output does.
// Reset clears the line state and drops out_valid. No clearing pass.
`include "assert_macros.svh"

module order_command_line_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          char_code,
    input  logic                has_char,
    input  logic                end_of_line,
    input  logic [63:0]         line_seq,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         seq_out,
    output logic [3:0]          error_code,
    output logic [1:0]          msg_kind,
    output logic                side_ask,
    output logic signed [63:0]  price,
    output logic [31:0]         quantity,
    output logic [63:0]         order_handle,
    output logic [1:0]          tif_code,
    output logic [31:0]         participant
);

    // line state
    logic [2:0]   tok_cnt_reg,  tok_cnt_next;
    logic         too_many_reg, too_many_next;
    logic         in_tok_reg,   in_tok_next;
    logic [3:0]   pos_reg,      pos_next;
    logic [8:0]   kw_reg,       kw_next;
    ocl_pkg::cmd_t cmd_reg,     cmd_next;
    logic [63:0]  acc_reg,      acc_next;
    logic         neg_reg, neg_next, ovf_reg, ovf_next;
    logic         bad_reg, bad_next, emp_reg, emp_next;
    logic [63:0]  hprice_reg,   hprice_next;
    logic [31:0]  hqty_reg,     hqty_next;
    logic [31:0]  hpart_reg,    hpart_next;
    logic         hside_reg,    hside_next;
    logic [1:0]   htif_reg,     htif_next;
    logic [1:0]   seen_reg,     seen_next;
    ocl_pkg::err_t ferr_reg,    ferr_next;

    // result register
    logic         ovalid_reg;
    logic [63:0]  seq_reg;
    logic [3:0]   err_reg;
    logic [1:0]   kind_reg;
    logic         side_reg;
    logic [63:0]  price_reg;
    logic [31:0]  qty_reg;
    logic [63:0]  handle_reg;
    logic [1:0]   tif_reg;
    logic [31:0]  part_reg;

    logic         in_fire;
    logic         res_load;

    assign in_ready = !ovalid_reg || out_ready || !end_of_line;
    assign in_fire  = in_valid && in_ready;
    assign res_load = in_fire && end_of_line;

    // next-state logic for one character and the line end
    logic [3:0]   err_c;
    logic [1:0]   kind_c;
    logic         side_c;
    logic [63:0]  price_c;
    logic [31:0]  qty_c;
    logic [63:0]  handle_c;
    logic [1:0]   tif_c;
    logic [31:0]  part_c;

    always_comb
    begin
        logic         is_sp;
        logic         run;
        logic [2:0]   idx;
        ocl_pkg::nkind_t kind;
        logic [3:0]   start;
        logic [63:0]  lim;
        logic [63:0]  dig;
        logic [63:0]  acc_x10;
        logic [67:0]  prod;
        logic         fin;
        logic         num_ok;
        logic         tif_hit;
        logic [1:0]   tif_val;
        logic         prefix;
        ocl_pkg::err_t ne;
        logic         cnt_bad;

        tok_cnt_next  = tok_cnt_reg;
        too_many_next = too_many_reg;
        in_tok_next   = in_tok_reg;
        pos_next      = pos_reg;
        kw_next       = kw_reg;
        cmd_next      = cmd_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        ovf_next      = ovf_reg;
        bad_next      = bad_reg;
        emp_next      = emp_reg;
        hprice_next   = hprice_reg;
        hqty_next     = hqty_reg;
        hpart_next    = hpart_reg;
        hside_next    = hside_reg;
        htif_next     = htif_reg;
        seen_next     = seen_reg;
        ferr_next     = ferr_reg;
        err_c = '0; kind_c = '0; side_c = 1'b0; price_c = '0; qty_c = '0;
        handle_c = '0; tif_c = '0; part_c = '0;
        is_sp = 1'b0; run = 1'b0; idx = '0; kind = ocl_pkg::NK_NONE;
        start = '0; lim = '0; dig = '0; acc_x10 = '0; prod = '0; fin = 1'b0;
        num_ok = 1'b0; tif_hit = 1'b0; tif_val = '0; prefix = 1'b0;
        ne = ocl_pkg::ERR_NONE; cnt_bad = 1'b0;

        is_sp = (char_code == 8'h20) || (char_code == 8'h09) ||
                (char_code == 8'h0D) || (char_code == 8'h0A);

        // character step
        if (in_fire && has_char && !too_many_reg) begin
            if (is_sp) begin
                fin = in_tok_reg;
            end else begin
                run = 1'b1;
                if (!in_tok_reg) begin
                    if (tok_cnt_reg >= 3'(ocl_pkg::MAX_TOKENS)) begin
                        too_many_next = 1'b1;
                        run = 1'b0;
                    end else begin
                        tok_cnt_next = tok_cnt_reg + 3'd1;
                        in_tok_next  = 1'b1;
                        pos_next     = '0;
                        kw_next      = '1;
                        acc_next     = '0;
                        neg_next = 1'b0; ovf_next = 1'b0;
                        bad_next = 1'b0; emp_next = 1'b1;
                    end
                end
            end
        end
        if (in_fire && end_of_line && in_tok_next && !too_many_next)
            fin = 1'b1;

        if (run) begin
            idx = tok_cnt_next - 3'd1;
            // keyword matching
            for (int k = 0; k < ocl_pkg::KW_COUNT; k++) begin
                if (!(pos_next < ocl_pkg::kw_len(k) &&
                      char_code == ocl_pkg::kw_char(k, pos_next)) &&
                    !(k == ocl_pkg::KW_PART &&
                      pos_next >= 4'(ocl_pkg::PART_LEN)))
                    kw_next[k] = 1'b0;
            end
            case (cmd_reg)
                ocl_pkg::CMD_LIMIT:
                    kind = (idx == 3'd2) ? ocl_pkg::NK_PRICE :
                           (idx == 3'd3) ? ocl_pkg::NK_QTY :
                           (idx >= 3'd4) ? ocl_pkg::NK_PART : ocl_pkg::NK_NONE;
                ocl_pkg::CMD_MARKET:
                    kind = (idx == 3'd2) ? ocl_pkg::NK_QTY : ocl_pkg::NK_NONE;
                ocl_pkg::CMD_CANCEL:
                    kind = (idx == 3'd1) ? ocl_pkg::NK_HANDLE : ocl_pkg::NK_NONE;
                default:
                    kind = ocl_pkg::NK_NONE;
            endcase
            start = (kind == ocl_pkg::NK_PART) ? 4'(ocl_pkg::PART_LEN) : 4'd0;
            if (kind != ocl_pkg::NK_NONE && pos_next >= start) begin
                if (pos_next == start && char_code == "-" &&
                    kind == ocl_pkg::NK_PRICE) begin
                    neg_next = 1'b1;
                end else if (char_code < "0" || char_code > "9") begin
                    bad_next = 1'b1;
                end else begin
                    emp_next = 1'b0;
                    if (!ovf_next) begin
                        dig = {60'd0, char_code[3:0]};
                        case (kind)
                            ocl_pkg::NK_PRICE:
                                lim = ocl_pkg::umax(ocl_pkg::PRICE_BITS - 1) +
                                      {63'd0, neg_next};
                            ocl_pkg::NK_QTY:
                                lim = ocl_pkg::umax(ocl_pkg::QTY_BITS);
                            ocl_pkg::NK_HANDLE:
                                lim = ocl_pkg::umax(ocl_pkg::HANDLE_BITS);
                            default:
                                lim = ocl_pkg::umax(ocl_pkg::PARTICIPANT_BITS);
                        endcase
                        // acc*10 + d <= lim, checked exactly in 68 bits
                        acc_x10 = (acc_next << 3) + (acc_next << 1);
                        prod = ({4'd0, acc_next} << 3) + ({4'd0, acc_next} << 1)
                               + {4'd0, dig};
                        if (prod > {4'd0, lim})
                            ovf_next = 1'b1;
                        else
                            acc_next = acc_x10 + dig;
                    end
                end
            end
            if (pos_next < 4'd15) pos_next = pos_next + 4'd1;
        end

        // token close
        if (fin) begin
            idx = tok_cnt_next - 3'd1;
            in_tok_next = 1'b0;
            num_ok = !ovf_next && !bad_next && !emp_next;
            if (idx == 3'd0) begin
                if (kw_next[ocl_pkg::KW_LIMIT] && pos_next == 4'd5)
                    cmd_next = ocl_pkg::CMD_LIMIT;
                else if (kw_next[ocl_pkg::KW_MARKET] && pos_next == 4'd6)
                    cmd_next = ocl_pkg::CMD_MARKET;
                else if (kw_next[ocl_pkg::KW_CANCEL] && pos_next == 4'd6)
                    cmd_next = ocl_pkg::CMD_CANCEL;
                else
                    cmd_next = ocl_pkg::CMD_NONE;
            end else if (cmd_reg != ocl_pkg::CMD_NONE) begin
                if (idx == 3'd1) begin
                    if (cmd_reg == ocl_pkg::CMD_CANCEL) begin
                        if (num_ok) hprice_next = acc_next;
                        else ne = ocl_pkg::ERR_HANDLE;
                    end else if (kw_next[ocl_pkg::KW_BID] && pos_next == 4'd3)
                        hside_next = 1'b0;
                    else if (kw_next[ocl_pkg::KW_ASK] && pos_next == 4'd3)
                        hside_next = 1'b1;
                    else
                        ne = ocl_pkg::ERR_SIDE;
                end else if (cmd_reg == ocl_pkg::CMD_MARKET && idx == 3'd2) begin
                    if (num_ok) hqty_next = acc_next[31:0];
                    else ne = ocl_pkg::ERR_QTY;
                end else if (cmd_reg == ocl_pkg::CMD_LIMIT) begin
                    if (idx == 3'd2) begin
                        if (!num_ok) ne = ocl_pkg::ERR_PRICE;
                        else if (neg_next) hprice_next = 64'd0 - acc_next;
                        else hprice_next = acc_next;
                    end else if (idx == 3'd3) begin
                        if (num_ok) hqty_next = acc_next[31:0];
                        else ne = ocl_pkg::ERR_QTY;
                    end else begin
                        // trailers
                        if (pos_next == 4'd3) begin
                            if (kw_next[ocl_pkg::KW_GTC]) begin
                                tif_hit = 1'b1; tif_val = ocl_pkg::TIF_GTC;
                            end else if (kw_next[ocl_pkg::KW_IOC]) begin
                                tif_hit = 1'b1; tif_val = ocl_pkg::TIF_IOC;
                            end else if (kw_next[ocl_pkg::KW_FOK]) begin
                                tif_hit = 1'b1; tif_val = ocl_pkg::TIF_FOK;
                            end
                        end
                        prefix = kw_next[ocl_pkg::KW_PART] &&
                                 pos_next >= 4'(ocl_pkg::PART_LEN);
                        if (tif_hit) begin
                            if (seen_reg[0]) ne = ocl_pkg::ERR_TIF;
                            else begin
                                seen_next[0] = 1'b1;
                                htif_next = tif_val;
                            end
                        end else if (prefix && num_ok) begin
                            if (seen_reg[1]) ne = ocl_pkg::ERR_PART;
                            else begin
                                seen_next[1] = 1'b1;
                                hpart_next = acc_next[31:0];
                            end
                        end else
                            ne = prefix ? ocl_pkg::ERR_PART : ocl_pkg::ERR_TIF;
                    end
                end
            end
            if (ferr_reg == ocl_pkg::ERR_NONE && ne != ocl_pkg::ERR_NONE)
                ferr_next = ne;
        end

        // line end: build the result and clear the line
        if (res_load) begin
            cnt_bad = (cmd_next == ocl_pkg::CMD_LIMIT  && tok_cnt_next < 3'd4) ||
                      (cmd_next == ocl_pkg::CMD_MARKET && tok_cnt_next != 3'd3) ||
                      (cmd_next == ocl_pkg::CMD_CANCEL && tok_cnt_next != 3'd2);
            if (tok_cnt_next == 3'd0)          err_c = ocl_pkg::ERR_EMPTY;
            else if (too_many_next)            err_c = ocl_pkg::ERR_COUNT;
            else if (cmd_next == ocl_pkg::CMD_NONE) err_c = ocl_pkg::ERR_CMD;
            else if (cnt_bad)                  err_c = ocl_pkg::ERR_COUNT;
            else                               err_c = ferr_next;
            if (err_c == ocl_pkg::ERR_NONE) begin
                kind_c = cmd_next - 2'd1;
                case (cmd_next)
                    ocl_pkg::CMD_LIMIT: begin
                        side_c = hside_next; price_c = hprice_next;
                        qty_c = hqty_next; tif_c = htif_next; part_c = hpart_next;
                    end
                    ocl_pkg::CMD_MARKET: begin
                        side_c = hside_next; qty_c = hqty_next;
                    end
                    default:
                        handle_c = hprice_next;
                endcase
            end
            tok_cnt_next = '0; too_many_next = 1'b0; in_tok_next = 1'b0;
            pos_next = '0; kw_next = '1; cmd_next = ocl_pkg::CMD_NONE;
            acc_next = '0; neg_next = 1'b0; ovf_next = 1'b0; bad_next = 1'b0;
            emp_next = 1'b0; hprice_next = '0; hqty_next = '0; hpart_next = '0;
            hside_next = 1'b0; htif_next = '0; seen_next = '0;
            ferr_next = ocl_pkg::ERR_NONE;
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_cnt_reg <= '0; too_many_reg <= 1'b0; in_tok_reg <= 1'b0;
            pos_reg <= '0; kw_reg <= '1; cmd_reg <= ocl_pkg::CMD_NONE;
            acc_reg <= '0; neg_reg <= 1'b0; ovf_reg <= 1'b0; bad_reg <= 1'b0;
            emp_reg <= 1'b0; hprice_reg <= '0; hqty_reg <= '0; hpart_reg <= '0;
            hside_reg <= 1'b0; htif_reg <= '0; seen_reg <= '0;
            ferr_reg <= ocl_pkg::ERR_NONE;
        end else begin
            tok_cnt_reg <= tok_cnt_next; too_many_reg <= too_many_next;
            in_tok_reg <= in_tok_next; pos_reg <= pos_next; kw_reg <= kw_next;
            cmd_reg <= cmd_next; acc_reg <= acc_next; neg_reg <= neg_next;
            ovf_reg <= ovf_next; bad_reg <= bad_next; emp_reg <= emp_next;
            hprice_reg <= hprice_next; hqty_reg <= hqty_next;
            hpart_reg <= hpart_next; hside_reg <= hside_next;
            htif_reg <= htif_next; seen_reg <= seen_next; ferr_reg <= ferr_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (res_load)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load) begin
            seq_reg <= line_seq; err_reg <= err_c; kind_reg <= kind_c;
            side_reg <= side_c; price_reg <= price_c; qty_reg <= qty_c;
            handle_reg <= handle_c; tif_reg <= tif_c; part_reg <= part_c;
        end
    end

    assign out_valid     = ovalid_reg;
    assign seq_out       = seq_reg;
    assign error_code    = err_reg;
    assign msg_kind      = kind_reg;
    assign side_ask      = side_reg;
    assign price         = price_reg;
    assign quantity      = qty_reg;
    assign order_handle  = handle_reg;
    assign tif_code      = tif_reg;
    assign participant   = part_reg;

    // checks
    `ASSERT_IMPL(a_err_zero_fields, out_valid && error_code != ocl_pkg::ERR_NONE,
        msg_kind == 2'd0 && price == 64'd0 && quantity == 32'd0, "error result carries data")
    `ASSERT_NEXT(a_line_cleared, res_load,
        tok_cnt_reg == 3'd0 && !in_tok_reg && !too_many_reg, "line state not cleared")
    `ASSERT_IMPL(a_tok_bound, 1'b1,
        tok_cnt_reg <= 3'(ocl_pkg::MAX_TOKENS), "token count beyond limit")

endmodule
